/* hw/rtl/bdp_pkg.sv */
`default_nettype none
package bdp_pkg;

	localparam int MaxDims = 64;
	localparam int MaxSegs = 8;
	localparam int DimW = $clog2(MaxDims);
	localparam int CntW = DimW + 1;
	localparam int SegW = $clog2(MaxSegs);
	localparam int LgW = 2;
	localparam int EnergyW = 32;
	localparam int SumW = EnergyW + DimW;
	localparam int ErrW = 2;
	localparam logic [LgW-1:0] SegLog2Reset = LgW'(2);

	localparam logic [ErrW-1:0] ErrNone = 2'd0;
	localparam logic [ErrW-1:0] ErrCount = 2'd1;
	localparam logic [ErrW-1:0] ErrOverflow = 2'd2;

	// One finished set handed from the loader to the engine.
	typedef struct packed {
		logic [ErrW-1:0] err;
		logic [CntW-1:0] n;
		logic [LgW-1:0] lg;
	} job_t;

	// Engine status seen by the loader.
	typedef struct packed {
		logic unlock;
	} back_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_RDI,
		ST_LATI,
		ST_RDJ,
		ST_CMPJ,
		ST_WR,
		ST_DINIT,
		ST_RDO,
		ST_RDE,
		ST_LATE,
		ST_SCAN,
		ST_PUT,
		ST_ERD,
		ST_ELD
	} back_state_t;

endpackage
`default_nettype wire

/* hw/rtl/bdp_in_if.sv */
`default_nettype none
interface bdp_in_if;
	logic valid;
	logic ready;
	logic [31:0] energy;
	logic last;
	modport source (output valid, output energy, output last, input ready);
	modport sink (input valid, input energy, input last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bdp_out_if.sv */
`default_nettype none
interface bdp_out_if;
	logic valid;
	logic ready;
	logic [5:0] position;
	logic [5:0] dim_index;
	logic [2:0] segment;
	logic [6:0] nonzero_len;
	logic [1:0] error;
	logic last_out;
	modport source (output valid, output position, output dim_index, output segment,
		output nonzero_len, output error, output last_out, input ready);
	modport sink (input valid, input position, input dim_index, input segment,
		input nonzero_len, input error, input last_out, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bdp_ram.sv */
`default_nettype none
module bdp_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/bdp_job_fifo.sv */
`default_nettype none
module bdp_job_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire bdp_pkg::job_t push_job,
	input wire logic pop,
	output bdp_pkg::job_t head,
	output logic empty,
	output logic full
);
	import bdp_pkg::*;

	job_t slot_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] level_q;

	assign empty = (level_q == 2'd0);
	assign full = (level_q == 2'd2);
	assign head = slot_q[rd_q];

	// Two-entry queue of finished sets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			level_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				level_q <= level_q + 2'd1;
			end else if (pop && !push) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/bdp_front.sv */
`default_nettype none
module bdp_front (
	input wire logic clk,
	input wire logic arst_n,
	bdp_in_if.sink items,
	input wire logic [bdp_pkg::LgW-1:0] seg_log2,
	input wire bdp_pkg::back_status_t status,
	input wire logic queue_full,
	output logic push,
	output bdp_pkg::job_t push_job,
	output logic e_we,
	output logic [bdp_pkg::DimW-1:0] e_waddr,
	output logic [bdp_pkg::EnergyW-1:0] e_wdata
);
	import bdp_pkg::*;

	logic [CntW-1:0] cnt_q;
	logic lock_q;
	logic take;
	logic [CntW-1:0] n_set;
	logic [CntW-1:0] seg_mask;

	// The energy store is held while the engine still sorts or deals the last set.
	assign items.ready = !lock_q && !queue_full;
	assign take = items.valid && items.ready;

	assign e_we = take && (cnt_q < CntW'(MaxDims));
	assign e_waddr = cnt_q[DimW-1:0];
	assign e_wdata = items.energy;

	assign n_set = (cnt_q <= CntW'(MaxDims)) ? cnt_q + CntW'(1) : cnt_q;
	assign seg_mask = (CntW'(1) << seg_log2) - CntW'(1);

	// Classify a closed set.
	always_comb begin
		push = take && items.last;
		push_job.n = n_set;
		push_job.lg = seg_log2;
		if (n_set > CntW'(MaxDims)) begin
			push_job.err = ErrOverflow;
		end else if ((n_set & seg_mask) != '0) begin
			push_job.err = ErrCount;
		end else begin
			push_job.err = ErrNone;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lock_q <= 1'b0;
		end else begin
			if (take) begin
				cnt_q <= items.last ? '0 : n_set;
			end
			if (push && push_job.err == ErrNone) begin
				lock_q <= 1'b1;
			end else if (status.unlock) begin
				lock_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/bdp_back.sv */
`default_nettype none
module bdp_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire bdp_pkg::job_t head,
	input wire logic queue_empty,
	output logic pop,
	output bdp_pkg::back_status_t status,
	output logic [bdp_pkg::DimW-1:0] e_raddr,
	input wire logic [bdp_pkg::EnergyW-1:0] e_rdata,
	bdp_out_if.source results
);
	import bdp_pkg::*;

	back_state_t state_q, state_d;

	logic [ErrW-1:0] err_q;
	logic [CntW-1:0] n_q;
	logic [LgW-1:0] lg_q;
	logic [CntW-1:0] cap_q;
	logic [CntW-1:0] i_q;
	logic [CntW-1:0] j_q;
	logic [CntW-1:0] rank_q;
	logic [EnergyW-1:0] ei_q;
	logic [DimW-1:0] d_q;
	logic [EnergyW-1:0] e_q;
	logic [SegW-1:0] scan_q;
	logic found_q;
	logic [SegW-1:0] best_q;
	logic [SumW-1:0] best_sum_q;
	logic [CntW-1:0] best_fill_q;
	logic [CntW-1:0] best_nz_q;
	logic [SumW-1:0] sum_q [MaxSegs];
	logic [CntW-1:0] fill_q [MaxSegs];
	logic [CntW-1:0] nz_q [MaxSegs];
	logic [SegW-1:0] seg_q;
	logic [CntW-1:0] in_seg_q;

	logic ovalid_q;
	logic [DimW-1:0] opos_q;
	logic [DimW-1:0] odim_q;
	logic [SegW-1:0] oseg_q;
	logic [CntW-1:0] onz_q;
	logic [ErrW-1:0] oerr_q;
	logic olast_q;

	logic o_free;
	logic o_load;
	logic ranks_ahead;
	logic take_seg;
	logic [SegW-1:0] last_seg;
	logic [SegW+CntW-1:0] slot;

	logic o_we;
	logic [DimW-1:0] o_waddr;
	logic [DimW-1:0] o_raddr;
	logic [DimW-1:0] o_rdata;
	logic m_we;
	logic [DimW-1:0] m_waddr;
	logic [DimW-1:0] m_raddr;
	logic [DimW-1:0] m_rdata;

	bdp_ram #(.Width(DimW), .Depth(MaxDims)) u_order (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(i_q[DimW-1:0]),
		.raddr(o_raddr), .rdata(o_rdata)
	);

	bdp_ram #(.Width(DimW), .Depth(MaxDims)) u_members (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(d_q),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	// Result register: refilled when empty or being taken.
	assign o_free = !ovalid_q || results.ready;
	assign results.valid = ovalid_q;
	assign results.position = opos_q;
	assign results.dim_index = odim_q;
	assign results.segment = oseg_q;
	assign results.nonzero_len = onz_q;
	assign results.error = oerr_q;
	assign results.last_out = olast_q;

	// Dimension j ranks ahead of dimension i.
	assign ranks_ahead = (e_rdata > ei_q) || ((e_rdata == ei_q) && (j_q < i_q));
	// The scanned segment is the best so far among those not full.
	assign take_seg = (fill_q[scan_q] < cap_q) &&
		(!found_q || (sum_q[scan_q] < best_sum_q));
	assign last_seg = SegW'((CntW'(1) << lg_q) - CntW'(1));
	assign slot = SegW'(best_q) * cap_q + (SegW+CntW)'(best_fill_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!queue_empty) begin
					state_d = (head.err != ErrNone) ? ST_ERR : ST_RDI;
				end
			end
			ST_ERR: if (o_free) state_d = ST_IDLE;
			ST_RDI: state_d = ST_LATI;
			ST_LATI: state_d = ST_RDJ;
			ST_RDJ: state_d = ST_CMPJ;
			ST_CMPJ: begin
				state_d = (j_q + CntW'(1) == n_q) ? ST_WR : ST_RDJ;
			end
			ST_WR: state_d = (i_q + CntW'(1) == n_q) ? ST_DINIT : ST_RDI;
			ST_DINIT: state_d = ST_RDO;
			ST_RDO: state_d = ST_RDE;
			ST_RDE: state_d = ST_LATE;
			ST_LATE: state_d = ST_SCAN;
			ST_SCAN: if (scan_q == last_seg) state_d = ST_PUT;
			ST_PUT: state_d = (i_q + CntW'(1) == n_q) ? ST_ERD : ST_RDO;
			ST_ERD: state_d = ST_ELD;
			ST_ELD: begin
				if (o_free) begin
					state_d = (i_q + CntW'(1) == n_q) ? ST_IDLE : ST_ERD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory controls and handshakes decoded from the state.
	always_comb begin
		pop = 1'b0;
		status.unlock = 1'b0;
		o_we = 1'b0;
		m_we = 1'b0;
		o_load = 1'b0;
		e_raddr = i_q[DimW-1:0];
		o_waddr = rank_q[DimW-1:0];
		o_raddr = i_q[DimW-1:0];
		m_waddr = slot[DimW-1:0];
		m_raddr = i_q[DimW-1:0];
		unique case (state_q)
			ST_IDLE: pop = !queue_empty;
			ST_ERR: o_load = o_free;
			ST_RDJ: e_raddr = j_q[DimW-1:0];
			ST_WR: o_we = 1'b1;
			ST_RDE: e_raddr = o_rdata;
			ST_PUT: begin
				m_we = 1'b1;
				status.unlock = (i_q + CntW'(1) == n_q);
			end
			ST_ELD: o_load = o_free;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (o_load) begin
				ovalid_q <= 1'b1;
			end else if (results.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Working registers of the sort, the deal and the emit.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				err_q <= head.err;
				n_q <= head.n;
				lg_q <= head.lg;
				cap_q <= head.n >> head.lg;
				i_q <= '0;
			end
			ST_LATI: begin
				ei_q <= e_rdata;
				j_q <= '0;
				rank_q <= '0;
			end
			ST_CMPJ: begin
				if (ranks_ahead) rank_q <= rank_q + CntW'(1);
				j_q <= j_q + CntW'(1);
			end
			ST_WR: i_q <= (i_q + CntW'(1) == n_q) ? '0 : i_q + CntW'(1);
			ST_DINIT: begin
				for (int s = 0; s < MaxSegs; s++) begin
					sum_q[s] <= '0;
					fill_q[s] <= '0;
					nz_q[s] <= '0;
				end
			end
			ST_RDE: d_q <= o_rdata;
			ST_LATE: begin
				e_q <= e_rdata;
				scan_q <= '0;
				found_q <= 1'b0;
			end
			ST_SCAN: begin
				if (take_seg) begin
					best_q <= scan_q;
					best_sum_q <= sum_q[scan_q];
					best_fill_q <= fill_q[scan_q];
					best_nz_q <= nz_q[scan_q];
					found_q <= 1'b1;
				end
				scan_q <= scan_q + SegW'(1);
			end
			ST_PUT: begin
				sum_q[best_q] <= best_sum_q + SumW'(e_q);
				fill_q[best_q] <= best_fill_q + CntW'(1);
				if (e_q != '0) nz_q[best_q] <= best_nz_q + CntW'(1);
				i_q <= (i_q + CntW'(1) == n_q) ? '0 : i_q + CntW'(1);
				seg_q <= '0;
				in_seg_q <= '0;
			end
			ST_ELD: begin
				if (o_free) begin
					i_q <= i_q + CntW'(1);
					if (in_seg_q + CntW'(1) == cap_q) begin
						in_seg_q <= '0;
						seg_q <= seg_q + SegW'(1);
					end else begin
						in_seg_q <= in_seg_q + CntW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (o_load) begin
			if (state_q == ST_ERR) begin
				opos_q <= '0;
				odim_q <= '0;
				oseg_q <= '0;
				onz_q <= '0;
				oerr_q <= err_q;
				olast_q <= 1'b1;
			end else begin
				opos_q <= i_q[DimW-1:0];
				odim_q <= m_rdata;
				oseg_q <= seg_q;
				onz_q <= nz_q[seg_q];
				oerr_q <= ErrNone;
				olast_q <= (i_q + CntW'(1) == n_q);
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/balanced_dimension_partition.sv */
`default_nettype none
// Balanced dimension partition. Energies (unsigned Q16.16) are loaded one per
// cycle while ready is high; an item with last set closes the set, which is
// then sorted by descending energy (lower index first on ties), dealt greedily
// to the segment with the smallest running sum among those not full, and
// emitted one result per position, segment by segment. A set whose count is not
// a multiple of the segment count gives one result with error 1; more than 64
// items give error 2. The rank sort compares one pair at a time through the
// single energy memory read port; each result is read from the member memory
// before it is loaded. The loader takes the next set once the deal has ended.
module balanced_dimension_partition (
	input wire logic clk,
	input wire logic arst_n,
	bdp_in_if.sink items,
	bdp_out_if.source results,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import bdp_pkg::*;

	logic [LgW-1:0] seg_log2_q;
	back_status_t status;
	logic push;
	job_t push_job;
	job_t head;
	logic pop;
	logic q_empty;
	logic q_full;
	logic e_we;
	logic [DimW-1:0] e_waddr;
	logic [EnergyW-1:0] e_wdata;
	logic [DimW-1:0] e_raddr;
	logic [EnergyW-1:0] e_rdata;

	// Register file: one register at byte address zero.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-LgW){1'b0}}, seg_log2_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_log2_q <= SegLog2Reset;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			seg_log2_q <= pwdata[LgW-1:0];
		end
	end

	bdp_front u_front (
		.clk(clk), .arst_n(arst_n), .items(items), .seg_log2(seg_log2_q),
		.status(status), .queue_full(q_full), .push(push), .push_job(push_job),
		.e_we(e_we), .e_waddr(e_waddr), .e_wdata(e_wdata)
	);

	bdp_ram #(.Width(EnergyW), .Depth(MaxDims)) u_energy (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	bdp_job_fifo u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job),
		.pop(pop), .head(head), .empty(q_empty), .full(q_full)
	);

	bdp_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .queue_empty(q_empty),
		.pop(pop), .status(status), .e_raddr(e_raddr), .e_rdata(e_rdata),
		.results(results)
	);
endmodule
`default_nettype wire
